// ===== design/nnsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnsc_pkg
// Shared types, constants and helpers of the nearest-neighbor RGB565 scaler.
// ----------------------------------------------------------------------------
package nnsc_pkg;

    // default sizing
    localparam int SRC_MAX_W_DEF     = 512;
    localparam int SRC_MAX_H_DEF     = 256;
    localparam int DST_MAX_DEF       = 2048;
    localparam int MAX_INT_SCALE_DEF = 4;

    // fixed field widths
    localparam int PIX_BITS      = 16;
    localparam int SRC_W_BITS    = 10;
    localparam int SRC_H_BITS    = 9;
    localparam int DST_BITS      = 12;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int FRAC_BITS     = 16;
    localparam int ACC_BITS      = 32;
    localparam int SRC_IDX_BITS  = ACC_BITS - FRAC_BITS;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_HEIGHT = 2'd3;

    // register reset values
    localparam logic [SRC_W_BITS-1:0] SRC_WIDTH_RST  = 10'd320;
    localparam logic [SRC_H_BITS-1:0] SRC_HEIGHT_RST = 9'd240;
    localparam logic [DST_BITS-1:0]   DST_WIDTH_RST  = 12'd640;
    localparam logic [DST_BITS-1:0]   DST_HEIGHT_RST = 12'd480;

    // input functions
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // pixel format masks
    localparam logic [PIX_BITS-1:0] ALPHA_BIT = 16'h8000;
    localparam logic [PIX_BITS-1:0] RG_MASK   = 16'h7fe0;
    localparam logic [PIX_BITS-1:0] B_MASK    = 16'h001f;

    typedef struct packed {
        logic                func;
        logic [PIX_BITS-1:0] src_pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_BITS-1:0] out_pixel;
        logic                row_end;
        logic                frame_end;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic req;
        logic div_start;
        logic div_row;
        logic calc_idx;
        logic calc_addr;
        logic ram_rd;
        logic emit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_req;
        logic frame_first;
        logic div_done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [PIX_BITS-1:0] to_a1r5g5b5(input logic [PIX_BITS-1:0] p);
        return ALPHA_BIT | ((p >> 1) & RG_MASK) | (p & B_MASK);
    endfunction

endpackage
`default_nettype wire

// ===== design/nearest_neighbor_rgb565_scaler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_rgb565_scaler_unit
// Nearest-neighbor scaler: RGB565 frame store in, A1R5G5B5 raster out.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   in      | input     | i_in_valid/o_in_stall   | t_in_item (func, src_pixel)
//   out     | output    | o_out_valid/i_out_stall | t_out_item (pixel, marks)
//   cfg     | input     | i_cfg_valid/o_cfg_ready | index + 12-bit data
//
// a load transaction is taken in the idle state; loads can be accepted back to back
// a pixel request runs through accept, index clamp, address multiply,
// frame store read, output register load
// the first request of a frame also runs the two step divisions
// in the one-bit-per-cycle divider, ahead of the index clamp
// a stalled output holds the request at the output register load; no clearing pass after reset
// ----------------------------------------------------------------------------
module nearest_neighbor_rgb565_scaler_unit #(
    parameter int SRC_MAX_W     = nnsc_pkg::SRC_MAX_W_DEF,
    parameter int SRC_MAX_H     = nnsc_pkg::SRC_MAX_H_DEF,
    parameter int DST_MAX       = nnsc_pkg::DST_MAX_DEF,
    parameter int MAX_INT_SCALE = nnsc_pkg::MAX_INT_SCALE_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire nnsc_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output nnsc_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [nnsc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [nnsc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    nnsc_pkg::t_dp_cmd w_cmd;
    nnsc_pkg::t_dp_sts w_sts;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    nnsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    nnsc_dp #(
        .SRC_MAX_W     (SRC_MAX_W),
        .SRC_MAX_H     (SRC_MAX_H),
        .DST_MAX       (DST_MAX),
        .MAX_INT_SCALE (MAX_INT_SCALE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire

// ===== design/nnsc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nnsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/nnsc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnsc_div #(
    parameter int DVD_W = 26,
    parameter int DSR_W = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DSR_W-1:0] r_dsr;
    logic [DSR_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DSR_W:0]   w_trial;
    logic             w_fits;
    logic [DSR_W-1:0] n_rem;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dsr});
    assign n_rem   = w_fits ? DSR_W'(w_trial - {1'b0, r_dsr}) : DSR_W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVD_W-2:0], w_fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== design/nnsc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnsc_ctrl
// Sequencer: accepts transactions, runs frame-start divisions, address
// calculation, store read and result hand-off.
// ----------------------------------------------------------------------------
module nnsc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire nnsc_pkg::t_dp_sts i_sts,
    output nnsc_pkg::t_dp_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVC  = 4'd1;
    localparam logic [3:0] S_WAITC = 4'd2;
    localparam logic [3:0] S_DIVR  = 4'd3;
    localparam logic [3:0] S_WAITR = 4'd4;
    localparam logic [3:0] S_IDX   = 4'd5;
    localparam logic [3:0] S_ADR   = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_sts.is_req) begin
                        o_cmd.req = 1'b1;
                        n_state   = i_sts.frame_first ? S_DIVC : S_IDX;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_DIVC: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAITC;
            end
            S_WAITC: begin
                if (i_sts.div_done) begin
                    n_state = S_DIVR;
                end
            end
            S_DIVR: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_row   = 1'b1;
                n_state         = S_WAITR;
            end
            S_WAITR: begin
                if (i_sts.div_done) begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                o_cmd.calc_idx = 1'b1;
                n_state        = S_ADR;
            end
            S_ADR: begin
                o_cmd.calc_addr = 1'b1;
                n_state         = S_RD;
            end
            S_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // hold the read data until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== design/nnsc_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nnsc_dp
// Datapath: configuration registers, frame store, step divider, position
// counters, source address calculation and output register.
// ----------------------------------------------------------------------------
module nnsc_dp #(
    parameter int SRC_MAX_W     = nnsc_pkg::SRC_MAX_W_DEF,
    parameter int SRC_MAX_H     = nnsc_pkg::SRC_MAX_H_DEF,
    parameter int DST_MAX       = nnsc_pkg::DST_MAX_DEF,
    parameter int MAX_INT_SCALE = nnsc_pkg::MAX_INT_SCALE_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire nnsc_pkg::t_dp_cmd                    i_cmd,
    output nnsc_pkg::t_dp_sts                         o_sts,
    input  wire nnsc_pkg::t_in_item                   i_in_data,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [nnsc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [nnsc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output logic                                      o_out_valid,
    output nnsc_pkg::t_out_item                       o_out_data,
    input  wire logic                                 i_out_stall
);

    localparam int SW_W  = $clog2(SRC_MAX_W + 1);
    localparam int SH_W  = $clog2(SRC_MAX_H + 1);
    localparam int DW_W  = $clog2(DST_MAX + 1);
    localparam int XW    = $clog2(SRC_MAX_W);
    localparam int YW    = $clog2(SRC_MAX_H);
    localparam int CW    = $clog2(DST_MAX);
    localparam int SC_W  = $clog2(MAX_INT_SCALE + 1);
    localparam int DEPTH = SRC_MAX_W * SRC_MAX_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int SD_W  = (SW_W > SH_W) ? SW_W : SH_W;
    localparam int DVD_W = SD_W + nnsc_pkg::FRAC_BITS;
    localparam int TW    = SW_W + SH_W + 1;
    localparam int EW    = DW_W + 1;
    localparam int PW    = YW + SW_W;
    localparam int IW    = nnsc_pkg::SRC_IDX_BITS;
    localparam int AC_W  = nnsc_pkg::ACC_BITS;
    localparam int PIX_W = nnsc_pkg::PIX_BITS;

    // configuration
    logic [nnsc_pkg::SRC_W_BITS-1:0] r_src_w;
    logic [nnsc_pkg::SRC_H_BITS-1:0] r_src_h;
    logic [nnsc_pkg::DST_BITS-1:0]   r_dst_w;
    logic [nnsc_pkg::DST_BITS-1:0]   r_dst_h;

    logic [SW_W-1:0] w_sw;
    logic [SH_W-1:0] w_sh;
    logic [DW_W-1:0] w_dw;
    logic [DW_W-1:0] w_dh;

    // sequencing state
    logic [AW-1:0]   r_load_idx;
    logic [CW-1:0]   r_out_col;
    logic [CW-1:0]   r_out_row;
    logic [AC_W-1:0] r_col_acc;
    logic [AC_W-1:0] r_row_acc;
    logic [AC_W-1:0] r_col_step;
    logic [AC_W-1:0] r_row_step;
    logic [SC_W-1:0] r_int_scale;
    // quotient and remainder of the position by the integer scale
    logic [CW-1:0]   r_cq;
    logic [SC_W-1:0] r_cr;
    logic [CW-1:0]   r_rq;
    logic [SC_W-1:0] r_rr;
    logic            r_div_row;

    // address path
    logic [XW-1:0]   r_sx;
    logic [YW-1:0]   r_sy;
    logic [AW-1:0]   r_rd_addr;

    // output register
    logic            r_out_valid;
    nnsc_pkg::t_out_item r_out_data;

    logic [SC_W-1:0]  w_scale;
    logic [DVD_W-1:0] w_dividend;
    logic [DW_W-1:0]  w_divisor;
    logic             w_div_done;
    logic [DVD_W-1:0] w_quotient;
    logic [TW-1:0]    w_load_next;
    logic [TW-1:0]    w_total;
    logic [IW-1:0]    w_sx_raw;
    logic [IW-1:0]    w_sy_raw;
    logic [PW-1:0]    w_prod;
    logic [EW-1:0]    w_col_next;
    logic [EW-1:0]    w_row_next;
    logic             w_row_end;
    logic             w_frame_end;
    logic             w_out_free;
    logic [PIX_W-1:0] w_rdata;
    logic [CW-1:0]    n_cq;
    logic [SC_W-1:0]  n_cr;
    logic [CW-1:0]    n_rq;
    logic [SC_W-1:0]  n_rr;

    // saturate registers into their usable ranges
    assign w_sw = (r_src_w == '0) ? SW_W'(1) :
                  (32'(r_src_w) > 32'(SRC_MAX_W)) ? SW_W'(SRC_MAX_W) : SW_W'(r_src_w);
    assign w_sh = (r_src_h == '0) ? SH_W'(1) :
                  (32'(r_src_h) > 32'(SRC_MAX_H)) ? SH_W'(SRC_MAX_H) : SH_W'(r_src_h);
    assign w_dw = (r_dst_w == '0) ? DW_W'(1) :
                  (32'(r_dst_w) > 32'(DST_MAX)) ? DW_W'(DST_MAX) : DW_W'(r_dst_w);
    assign w_dh = (r_dst_h == '0) ? DW_W'(1) :
                  (32'(r_dst_h) > 32'(DST_MAX)) ? DW_W'(DST_MAX) : DW_W'(r_dst_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= nnsc_pkg::SRC_WIDTH_RST;
            r_src_h <= nnsc_pkg::SRC_HEIGHT_RST;
            r_dst_w <= nnsc_pkg::DST_WIDTH_RST;
            r_dst_h <= nnsc_pkg::DST_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nnsc_pkg::CFG_SRC_WIDTH: begin
                    r_src_w <= nnsc_pkg::SRC_W_BITS'(i_cfg_data);
                end
                nnsc_pkg::CFG_SRC_HEIGHT: begin
                    r_src_h <= nnsc_pkg::SRC_H_BITS'(i_cfg_data);
                end
                nnsc_pkg::CFG_DST_WIDTH: begin
                    r_dst_w <= i_cfg_data;
                end
                nnsc_pkg::CFG_DST_HEIGHT: begin
                    r_dst_h <= i_cfg_data;
                end
            endcase
        end
    end

    // integer scale: same multiple, up to MAX_INT_SCALE, in both axes, else fixed-point mode
    always_comb begin
        w_scale = '0;
        for (int k = 1; k <= MAX_INT_SCALE; k++) begin
            if ((32'(w_dw) == 32'(w_sw) * 32'(k)) && (32'(w_dh) == 32'(w_sh) * 32'(k))) begin
                w_scale = SC_W'(k);
            end
        end
    end

    assign w_dividend = i_cmd.div_row ?
                        {SD_W'(w_sh), {nnsc_pkg::FRAC_BITS{1'b0}}} :
                        {SD_W'(w_sw), {nnsc_pkg::FRAC_BITS{1'b0}}};
    assign w_divisor  = i_cmd.div_row ? w_dh : w_dw;

    nnsc_div #(
        .DVD_W (DVD_W),
        .DSR_W (DW_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // load index wraps after the last pixel of the source frame
    assign w_load_next = TW'(r_load_idx) + TW'(1);
    assign w_total     = TW'(w_sw) * TW'(w_sh);

    nnsc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_load_idx),
        .i_wdata (i_in_data.src_pixel),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    // source index before clamping
    assign w_sx_raw = (r_int_scale != '0) ? IW'(r_cq) : r_col_acc[AC_W-1 -: IW];
    assign w_sy_raw = (r_int_scale != '0) ? IW'(r_rq) : r_row_acc[AC_W-1 -: IW];
    assign w_prod   = {{SW_W{1'b0}}, r_sy} * {{YW{1'b0}}, w_sw};

    assign w_col_next  = EW'(r_out_col) + EW'(1);
    assign w_row_next  = EW'(r_out_row) + EW'(1);
    assign w_row_end   = (w_col_next >= EW'(w_dw));
    assign w_frame_end = w_row_end && (w_row_next >= EW'(w_dh));

    assign n_cq = (SC_W'(r_cr + SC_W'(1)) == r_int_scale) ? CW'(r_cq + CW'(1)) : r_cq;
    assign n_cr = (SC_W'(r_cr + SC_W'(1)) == r_int_scale) ? '0 : SC_W'(r_cr + SC_W'(1));
    assign n_rq = (SC_W'(r_rr + SC_W'(1)) == r_int_scale) ? CW'(r_rq + CW'(1)) : r_rq;
    assign n_rr = (SC_W'(r_rr + SC_W'(1)) == r_int_scale) ? '0 : SC_W'(r_rr + SC_W'(1));

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx  <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_col_acc   <= '0;
            r_row_acc   <= '0;
            r_col_step  <= '0;
            r_row_step  <= '0;
            r_int_scale <= '0;
            r_cq        <= '0;
            r_cr        <= '0;
            r_rq        <= '0;
            r_rr        <= '0;
            r_div_row   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_load_idx <= (w_load_next >= w_total) ? '0 : AW'(w_load_next);
            end

            if (i_cmd.req && o_sts.frame_first) begin
                r_int_scale <= w_scale;
                r_col_acc   <= '0;
                r_row_acc   <= '0;
                r_cq        <= '0;
                r_cr        <= '0;
                r_rq        <= '0;
                r_rr        <= '0;
            end

            if (i_cmd.div_start) begin
                r_div_row <= i_cmd.div_row;
            end
            if (w_div_done) begin
                if (r_div_row) begin
                    r_row_step <= AC_W'(w_quotient);
                end else begin
                    r_col_step <= AC_W'(w_quotient);
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (w_frame_end) begin
                    r_out_col <= '0;
                    r_out_row <= '0;
                    r_col_acc <= '0;
                    r_row_acc <= '0;
                    r_cq      <= '0;
                    r_cr      <= '0;
                    r_rq      <= '0;
                    r_rr      <= '0;
                end else if (w_row_end) begin
                    r_out_col <= '0;
                    r_out_row <= CW'(w_row_next);
                    r_col_acc <= '0;
                    r_row_acc <= r_row_acc + r_row_step;
                    r_cq      <= '0;
                    r_cr      <= '0;
                    r_rq      <= n_rq;
                    r_rr      <= n_rr;
                end else begin
                    r_out_col <= CW'(w_col_next);
                    r_col_acc <= r_col_acc + r_col_step;
                    r_cq      <= n_cq;
                    r_cr      <= n_cr;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_idx) begin
            r_sx <= (w_sx_raw >= IW'(w_sw)) ? XW'(w_sw - SW_W'(1)) : XW'(w_sx_raw);
            r_sy <= (w_sy_raw >= IW'(w_sh)) ? YW'(w_sh - SH_W'(1)) : YW'(w_sy_raw);
        end
        if (i_cmd.calc_addr) begin
            r_rd_addr <= AW'(w_prod + PW'(r_sx));
        end
        if (i_cmd.emit) begin
            r_out_data.out_pixel <= nnsc_pkg::to_a1r5g5b5(w_rdata);
            r_out_data.row_end   <= w_row_end;
            r_out_data.frame_end <= w_frame_end;
        end
    end

    assign o_sts.is_req      = (i_in_data.func == nnsc_pkg::FUNC_REQUEST);
    assign o_sts.frame_first = (r_out_col == '0) && (r_out_row == '0);
    assign o_sts.div_done    = w_div_done;
    assign o_sts.out_free    = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the nearest-neighbor RGB565 scaler unit.
//
// Source frames are loaded, destination pixels are requested, and every output
// transaction is compared with an in-bench model of the scaler. Covers integer
// replication, fixed-point stepping, register saturation, load wrap, register
// changes in the middle of a frame, long output back-pressure and random
// traffic with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
    import nnsc_pkg::*;

    localparam int STORE_DEPTH           = SRC_MAX_W_DEF * SRC_MAX_H_DEF;
    localparam int DRAIN_CYCLES          = 80;
    localparam int RANDOM_ITEMS          = 80;
    localparam int QUIET_ITEMS           = 30;
    localparam int unsigned POS_MASK     = 32'h7ff;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    t_in_item                 in_data   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out_item                out_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // scaler model state
    logic [PIX_BITS-1:0]   store_img [STORE_DEPTH];
    bit                    store_written [STORE_DEPTH];
    int unsigned           load_ptr   = 0;
    int unsigned           col_pos    = 0;
    int unsigned           row_pos    = 0;
    int unsigned           rep_factor = 0;
    logic [ACC_BITS-1:0]   col_acc    = '0;
    logic [ACC_BITS-1:0]   row_acc    = '0;
    logic [ACC_BITS-1:0]   col_inc    = '0;
    logic [ACC_BITS-1:0]   row_inc    = '0;
    logic [SRC_W_BITS-1:0] reg_src_w  = SRC_WIDTH_RST;
    logic [SRC_H_BITS-1:0] reg_src_h  = SRC_HEIGHT_RST;
    logic [DST_BITS-1:0]   reg_dst_w  = DST_WIDTH_RST;
    logic [DST_BITS-1:0]   reg_dst_h  = DST_HEIGHT_RST;

    t_out_item pending_pixels [$];
    int        error_count  = 0;
    int        random_items = 0;
    int        hold_req     = 0;
    int        stall_burst  = 0;
    bit        idle_on      = 1'b1;
    bit        frame_done   = 1'b0;

    nearest_neighbor_rgb565_scaler_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned clip(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned src_cols();
        return clip(reg_src_w, SRC_MAX_W_DEF);
    endfunction

    function automatic int unsigned src_rows();
        return clip(reg_src_h, SRC_MAX_H_DEF);
    endfunction

    function automatic int unsigned dst_cols();
        return clip(reg_dst_w, DST_MAX_DEF);
    endfunction

    function automatic int unsigned dst_rows();
        return clip(reg_dst_h, DST_MAX_DEF);
    endfunction

    // every entry below n holds a pixel
    function automatic bit prefix_covered(input int unsigned n);
        for (int unsigned a = 0; a < n; a++)
            if (!store_written[a]) return 1'b0;
        return 1'b1;
    endfunction

    // every entry a request can reach under the current sizes holds a pixel
    function automatic bit store_covered();
        int unsigned total;
        total = src_cols() * src_rows();
        for (int unsigned a = 0; a < total; a++)
            if (!store_written[a]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void scaler_predict(input t_in_item item);
        int unsigned         sw, sh, dw, dh, sx, sy;
        logic [PIX_BITS-1:0] pix;
        t_out_item           res;
        sw = src_cols();
        sh = src_rows();
        if (item.func == FUNC_LOAD) begin
            store_img[load_ptr] = item.src_pixel;
            store_written[load_ptr] = 1'b1;
            load_ptr++;
            if (load_ptr >= sw * sh) load_ptr = 0;
            return;
        end
        dw = dst_cols();
        dh = dst_rows();
        // mode and steps are fixed at the first request of a frame
        if (col_pos == 0 && row_pos == 0) begin
            rep_factor = 0;
            if (dw % sw == 0 && dh % sh == 0 && dw / sw == dh / sh
                    && dw / sw <= MAX_INT_SCALE_DEF)
                rep_factor = dw / sw;
            col_acc = '0;
            row_acc = '0;
            if (rep_factor == 0) begin
                col_inc = ACC_BITS'((longint'(sw) << FRAC_BITS) / dw);
                row_inc = ACC_BITS'((longint'(sh) << FRAC_BITS) / dh);
            end else begin
                col_inc = '0;
                row_inc = '0;
            end
        end
        if (rep_factor != 0) begin
            sx = col_pos / rep_factor;
            sy = row_pos / rep_factor;
        end else begin
            sx = col_acc[ACC_BITS-1:FRAC_BITS];
            sy = row_acc[ACC_BITS-1:FRAC_BITS];
        end
        if (sx >= sw) sx = sw - 1;
        if (sy >= sh) sy = sh - 1;
        pix = store_img[sy * sw + sx];
        // alpha set, green loses its low bit
        res.out_pixel = {1'b1, pix[15:6], pix[4:0]};
        res.row_end   = (col_pos + 1 >= dw);
        res.frame_end = res.row_end && (row_pos + 1 >= dh);
        pending_pixels.push_back(res);
        if (res.frame_end) begin
            col_pos    = 0;
            row_pos    = 0;
            col_acc    = '0;
            row_acc    = '0;
            frame_done = 1'b1;
        end else if (res.row_end) begin
            col_pos = 0;
            row_pos = (row_pos + 1) & POS_MASK;
            col_acc = '0;
            row_acc = row_acc + row_inc;
        end else begin
            col_pos = (col_pos + 1) & POS_MASK;
            col_acc = col_acc + col_inc;
        end
    endfunction

    task automatic send_item(input logic op, input logic [PIX_BITS-1:0] pixel);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in_item'{op, pixel};
        do @(posedge clk); while (in_stall);
        scaler_predict(in_data);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        // trailing loads produce no output, give them time to retire
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SRC_WIDTH:  reg_src_w = val[SRC_W_BITS-1:0];
            CFG_SRC_HEIGHT: reg_src_h = val[SRC_H_BITS-1:0];
            CFG_DST_WIDTH:  reg_dst_w = val[DST_BITS-1:0];
            CFG_DST_HEIGHT: reg_dst_h = val[DST_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned sw, input int unsigned sh,
                             input int unsigned dw, input int unsigned dh);
        wait_idle();
        write_reg(CFG_SRC_WIDTH, CFG_DATA_BITS'(sw));
        write_reg(CFG_SRC_HEIGHT, CFG_DATA_BITS'(sh));
        write_reg(CFG_DST_WIDTH, CFG_DATA_BITS'(dw));
        write_reg(CFG_DST_HEIGHT, CFG_DATA_BITS'(dh));
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_store();
        while (!store_covered()) send_item(FUNC_LOAD, PIX_BITS'($urandom));
    endtask

    task automatic fill_prefix(input int unsigned n);
        while (!prefix_covered(n)) send_item(FUNC_LOAD, PIX_BITS'($urandom));
    endtask

    task automatic request_frame();
        frame_done = 1'b0;
        do send_item(FUNC_REQUEST, PIX_BITS'($urandom)); while (!frame_done);
    endtask

    // loads under the reset sizes, then a smaller frame makes the index wrap
    task automatic test_load_wrap();
        send_item(FUNC_LOAD, 16'hffff);
        send_item(FUNC_LOAD, 16'h0000);
        send_item(FUNC_LOAD, 16'h07e0);
        send_item(FUNC_LOAD, 16'hf81f);
        send_item(FUNC_LOAD, 16'h8001);
        configure(2, 2, 2, 2);
        repeat (6) send_item(FUNC_LOAD, PIX_BITS'($urandom));
        request_frame();
        request_frame();
    endtask

    task automatic test_integer_scales();
        for (int unsigned k = 1; k <= MAX_INT_SCALE_DEF; k++) begin
            configure(2, 1, 2 * k, k);
            fill_store();
            request_frame();
        end
    endtask

    task automatic test_fixed_point();
        configure(1, 1, 5, 5);      // equal multiple beyond the replication limit
        fill_store();
        request_frame();
        configure(2, 3, 4, 9);      // different multiples per axis
        fill_store();
        request_frame();
        configure(5, 4, 3, 2);      // downscale
        fill_store();
        request_frame();
        configure(5, 3, 7, 4);
        fill_store();
        request_frame();
    endtask

    task automatic test_saturation();
        configure(0, 0, 0, 0);
        fill_store();
        repeat (3) request_frame();
    endtask

    // saturated sizes set the steps; the frame is then cut short by a small destination
    task automatic test_extremes();
        configure(1023, 1, 4095, 1);
        fill_prefix(4);
        repeat (10) send_item(FUNC_REQUEST, PIX_BITS'($urandom));
        configure(1023, 1, 11, 1);
        request_frame();
        configure(1, 511, 1, 4095);
        repeat (12) send_item(FUNC_REQUEST, PIX_BITS'($urandom));
        configure(1, 511, 1, 13);
        request_frame();
    endtask

    // sizes change while a frame is half done; indices get clamped
    task automatic test_mid_frame_config();
        configure(4, 4, 6, 6);
        fill_store();
        repeat (10) send_item(FUNC_REQUEST, PIX_BITS'($urandom));
        configure(3, 3, 4, 6);
        fill_store();
        request_frame();
        configure(4, 4, 8, 8);
        fill_store();
        repeat (19) send_item(FUNC_REQUEST, PIX_BITS'($urandom));
        configure(2, 2, 2, 8);
        fill_store();
        request_frame();
    endtask

    task automatic test_backpressure();
        configure(4, 4, 4, 4);
        fill_store();
        idle_on  = 1'b0;
        hold_req = 120;
        repeat (24) send_item(FUNC_REQUEST, PIX_BITS'($urandom));
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned sw, sh, dw, dh, k, items;
        while (random_items < RANDOM_ITEMS) begin
            sw = $urandom_range(1, 8);
            sh = $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0: begin
                    k  = $urandom_range(1, 5);
                    dw = sw * k;
                    dh = sh * k;
                end
                1: begin
                    dw = sw * $urandom_range(1, 4);
                    dh = sh * $urandom_range(1, 4);
                end
                2: begin
                    dw = $urandom_range(1, sw);
                    dh = $urandom_range(1, sh);
                end
                default: begin
                    dw = $urandom_range(1, 24);
                    dh = $urandom_range(1, 24);
                end
            endcase
            // zero registers now and then, the block treats them as one
            if ($urandom_range(0, 7) == 0) sw = 0;
            if ($urandom_range(0, 7) == 0) dh = 0;
            idle_on = (random_items < RANDOM_ITEMS - QUIET_ITEMS) &&
                      ($urandom_range(0, 3) != 0);
            configure(sw, sh, dw, dh);
            fill_store();
            items = $urandom_range(20, 40);
            repeat (items) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(FUNC_LOAD, PIX_BITS'($urandom));
                else
                    send_item(FUNC_REQUEST, PIX_BITS'($urandom));
            end
            random_items += items;
        end
    endtask

    // output stall: long hold when asked, otherwise short random bursts while idle_on is set
    always @(posedge clk) begin
        if (hold_req > 0) begin
            hold_req = hold_req - 1;
            out_stall <= 1'b1;
        end else if (stall_burst > 0) begin
            stall_burst = stall_burst - 1;
            out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_burst = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        t_out_item exp_px;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected output transaction %h", out_data);
                error_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (out_data.out_pixel !== exp_px.out_pixel) begin
                    $error("out_pixel: expected %h, got %h", exp_px.out_pixel,
                           out_data.out_pixel);
                    error_count++;
                end
                if (out_data.row_end !== exp_px.row_end) begin
                    $error("row_end: expected %b, got %b", exp_px.row_end, out_data.row_end);
                    error_count++;
                end
                if (out_data.frame_end !== exp_px.frame_end) begin
                    $error("frame_end: expected %b, got %b", exp_px.frame_end,
                           out_data.frame_end);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("nearest_neighbor_rgb565_scaler_unit verification failed");
        $finish;
    end

    initial begin
        int wait_cycles;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_load_wrap();
        test_integer_scales();
        test_fixed_point();
        test_saturation();
        test_extremes();
        test_mid_frame_config();
        test_backpressure();
        test_random_traffic();
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_pixels.size() != 0 && wait_cycles < 100000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", pending_pixels.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("nearest_neighbor_rgb565_scaler_unit verification clean");
        end else begin
            $display("nearest_neighbor_rgb565_scaler_unit verification failed");
        end
        $finish;
    end

endmodule
